### sv/segment_intersection_test_unit_assert.svh
// ----------------------------------------------------------------------------
// segment intersection test unit assertion macros
// Concurrent check wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_TEST_UNIT_ASSERT_SVH
`define SEGMENT_INTERSECTION_TEST_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// condition must never hold outside reset
`define SIT_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("segment intersection check failed");
// antecedent implies consequent in the same cycle
`define SIT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segment intersection check failed");
`else
`define SIT_ASSERT_NEVER(label, clk, rst_n, cond)
`define SIT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

### sv/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Widths, result kinds and pipeline payload type of the segment test unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sit_pkg;

  localparam int CW  = 16;          // coordinate width, Q12.4
  localparam int FB  = 16;          // fraction bits
  localparam int DW  = CW + 1;      // coordinate difference width
  localparam int PW  = 2 * DW;      // product width
  localparam int SW  = PW + 2;      // sum of up to four products
  localparam int MW  = PW;          // divisor / remainder width
  localparam int RW  = MW + 1;      // shifted remainder width
  localparam int QW  = FB + 1;      // fraction width, Q1.FB
  localparam int XW  = DW + QW + 1; // point offset product width

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_POINT   = 2'd1,
    KIND_OVERLAP = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    logic signed [CW-1:0]  s1x;
    logic signed [CW-1:0]  s1y;
    logic signed [DW-1:0]  d1x;
    logic signed [DW-1:0]  d1y;
  } side_t;

endpackage

### sv/segment_intersection_test_unit.sv
// ----------------------------------------------------------------------------
// segment_intersection_test_unit
// Classifies two Q12.4 segments as disjoint, single point or collinear overlap.
// ----------------------------------------------------------------------------
// Fully pipelined: one segment pair may be started every cycle (busy_o stays
// low) and its result is flagged by done_o. The pipeline holds the fraction
// divider, one quotient bit per stage (17 stages), plus four stages for
// differences, products, sums and classification, and two for point
// reconstruction and the output register. Results are shown for one cycle
// only; the receiver must take them as they come.
`timescale 1ns / 1ps

`include "segment_intersection_test_unit_assert.svh"

module segment_intersection_test_unit import sit_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic signed [CW-1:0] seg1_start_x_i,
  input  logic signed [CW-1:0] seg1_start_y_i,
  input  logic signed [CW-1:0] seg1_end_x_i,
  input  logic signed [CW-1:0] seg1_end_y_i,
  input  logic signed [CW-1:0] seg2_start_x_i,
  input  logic signed [CW-1:0] seg2_start_y_i,
  input  logic signed [CW-1:0] seg2_end_x_i,
  input  logic signed [CW-1:0] seg2_end_y_i,
  output logic                 done_o,
  output logic [1:0]           hit_kind_o,
  output logic signed [CW-1:0] first_x_o,
  output logic signed [CW-1:0] first_y_o,
  output logic [QW-1:0]        first_fraction_o,
  output logic signed [CW-1:0] second_x_o,
  output logic signed [CW-1:0] second_y_o,
  output logic [QW-1:0]        second_fraction_o
);

  assign busy_o = 1'b0;

  // stage 1: differences
  logic                 v1_q;
  logic signed [CW-1:0] s1x_1_q, s1y_1_q;
  logic signed [DW-1:0] d1x_q, d1y_q, d2x_q, d2y_q, px_q, py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1x_1_q <= seg1_start_x_i;
    s1y_1_q <= seg1_start_y_i;
    d1x_q <= {seg1_end_x_i[CW-1], seg1_end_x_i} - {seg1_start_x_i[CW-1], seg1_start_x_i};
    d1y_q <= {seg1_end_y_i[CW-1], seg1_end_y_i} - {seg1_start_y_i[CW-1], seg1_start_y_i};
    d2x_q <= {seg2_end_x_i[CW-1], seg2_end_x_i} - {seg2_start_x_i[CW-1], seg2_start_x_i};
    d2y_q <= {seg2_end_y_i[CW-1], seg2_end_y_i} - {seg2_start_y_i[CW-1], seg2_start_y_i};
    px_q  <= {seg2_start_x_i[CW-1], seg2_start_x_i} - {seg1_start_x_i[CW-1], seg1_start_x_i};
    py_q  <= {seg2_start_y_i[CW-1], seg2_start_y_i} - {seg1_start_y_i[CW-1], seg1_start_y_i};
  end

  // stage 2: cross and dot products
  logic                 v2_q;
  logic signed [CW-1:0] s1x_2_q, s1y_2_q;
  logic signed [DW-1:0] d1x_2_q, d1y_2_q;
  logic signed [PW-1:0] den_a_q, den_b_q, c1_a_q, c1_b_q, c2_a_q, c2_b_q;
  logic signed [PW-1:0] len_a_q, len_b_q, a_a_q, a_b_q, t_a_q, t_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1x_2_q <= s1x_1_q;
    s1y_2_q <= s1y_1_q;
    d1x_2_q <= d1x_q;
    d1y_2_q <= d1y_q;
    den_a_q <= PW'(d1x_q * d2y_q);
    den_b_q <= PW'(d1y_q * d2x_q);
    c1_a_q  <= PW'(px_q * d1y_q);
    c1_b_q  <= PW'(py_q * d1x_q);
    c2_a_q  <= PW'(px_q * d2y_q);
    c2_b_q  <= PW'(py_q * d2x_q);
    len_a_q <= PW'(d1x_q * d1x_q);
    len_b_q <= PW'(d1y_q * d1y_q);
    a_a_q   <= PW'(px_q * d1x_q);
    a_b_q   <= PW'(py_q * d1y_q);
    t_a_q   <= PW'(d2x_q * d1x_q);
    t_b_q   <= PW'(d2y_q * d1y_q);
  end

  // stage 3: sums
  logic                 v3_q;
  logic signed [CW-1:0] s1x_3_q, s1y_3_q;
  logic signed [DW-1:0] d1x_3_q, d1y_3_q;
  logic signed [SW-1:0] den_q, c1_q, c2_q, len_q, a_q, b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1x_3_q <= s1x_2_q;
    s1y_3_q <= s1y_2_q;
    d1x_3_q <= d1x_2_q;
    d1y_3_q <= d1y_2_q;
    den_q <= SW'(den_a_q) - SW'(den_b_q);
    c1_q  <= SW'(c1_a_q) - SW'(c1_b_q);
    c2_q  <= SW'(c2_a_q) - SW'(c2_b_q);
    len_q <= SW'(len_a_q) + SW'(len_b_q);
    a_q   <= SW'(a_a_q) + SW'(a_b_q);
    b_q   <= SW'(a_a_q) + SW'(a_b_q) + SW'(t_a_q) + SW'(t_b_q);
  end

  // stage 4: classification, divider operands
  logic signed [SW-1:0] den_abs, c1_f, c2_f, lo_v, hi_v, ca_v, cb_v;
  logic                 cross_hit, col_hit;
  logic [MW-1:0]        n1_d, n2_d, m_d;
  kind_e                kind_d;

  always_comb begin
    den_abs = den_q[SW-1] ? -den_q : den_q;
    c1_f    = den_q[SW-1] ? -c1_q : c1_q;
    c2_f    = den_q[SW-1] ? -c2_q : c2_q;
    lo_v    = (a_q < b_q) ? a_q : b_q;
    hi_v    = (a_q < b_q) ? b_q : a_q;
    ca_v    = a_q[SW-1] ? '0 : ((a_q > len_q) ? len_q : a_q);
    cb_v    = b_q[SW-1] ? '0 : ((b_q > len_q) ? len_q : b_q);
    cross_hit = (den_q != '0) && !c2_f[SW-1] && (c2_f <= den_abs)
                && !c1_f[SW-1] && (c1_f <= den_abs);
    col_hit   = (den_q == '0) && (c1_q == '0) && (len_q != '0)
                && (lo_v <= len_q) && !hi_v[SW-1];
    kind_d = KIND_NONE;
    n1_d   = '0;
    n2_d   = '0;
    m_d    = MW'(1);
    if (cross_hit) begin
      kind_d = KIND_POINT;
      n1_d   = c2_f[MW-1:0];
      m_d    = den_abs[MW-1:0];
    end else if (col_hit) begin
      kind_d = (ca_v == cb_v) ? KIND_POINT : KIND_OVERLAP;
      n1_d   = ca_v[MW-1:0];
      n2_d   = cb_v[MW-1:0];
      m_d    = len_q[MW-1:0];
    end
  end

  logic          v4_q;
  logic [MW-1:0] n1_q, n2_q, m4_q;
  side_t         sd4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q <= n1_d;
    n2_q <= n2_d;
    m4_q <= m_d;
    sd4_q <= '{kind: kind_d, s1x: s1x_3_q, s1y: s1y_3_q, d1x: d1x_3_q, d1y: d1y_3_q};
  end

  // divider pipeline: one quotient bit per stage, msb first
  logic          vd_q [QW];
  logic [MW-1:0] r1_q [QW];
  logic [MW-1:0] r2_q [QW];
  logic [QW-1:0] q1_q [QW];
  logic [QW-1:0] q2_q [QW];
  logic [MW-1:0] md_q [QW];
  side_t         sdd_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [RW-1:0] sh1, sh2, rr1, rr2;
    logic [QW-1:0] qp1, qp2;
    logic [MW-1:0] m_in;
    side_t         sd_in;
    logic          v_in, bit1, bit2;

    if (k == 0) begin : g_first
      assign sh1   = {1'b0, n1_q};
      assign sh2   = {1'b0, n2_q};
      assign qp1   = '0;
      assign qp2   = '0;
      assign m_in  = m4_q;
      assign sd_in = sd4_q;
      assign v_in  = v4_q;
    end else begin : g_next
      assign sh1   = {r1_q[k-1], 1'b0};
      assign sh2   = {r2_q[k-1], 1'b0};
      assign qp1   = q1_q[k-1];
      assign qp2   = q2_q[k-1];
      assign m_in  = md_q[k-1];
      assign sd_in = sdd_q[k-1];
      assign v_in  = vd_q[k-1];
    end

    // compare and subtract
    always_comb begin
      bit1 = (sh1 >= {1'b0, m_in});
      bit2 = (sh2 >= {1'b0, m_in});
      rr1  = bit1 ? (sh1 - {1'b0, m_in}) : sh1;
      rr2  = bit2 ? (sh2 - {1'b0, m_in}) : sh2;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[k] <= 1'b0;
      end else begin
        vd_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      r1_q[k]  <= rr1[MW-1:0];
      r2_q[k]  <= rr2[MW-1:0];
      q1_q[k]  <= {qp1[QW-2:0], bit1};
      q2_q[k]  <= {qp2[QW-2:0], bit2};
      md_q[k]  <= m_in;
      sdd_q[k] <= sd_in;
    end
  end

  // point stage 1: offset products
  logic                 vp_q;
  side_t                sdp_q;
  logic [QW-1:0]        qf1_q, qf2_q;
  logic signed [XW-1:0] ox1_q, oy1_q, ox2_q, oy2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else begin
      vp_q <= vd_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sdp_q <= sdd_q[QW-1];
    qf1_q <= q1_q[QW-1];
    qf2_q <= q2_q[QW-1];
    ox1_q <= XW'(sdd_q[QW-1].d1x * signed'({1'b0, q1_q[QW-1]}));
    oy1_q <= XW'(sdd_q[QW-1].d1y * signed'({1'b0, q1_q[QW-1]}));
    ox2_q <= XW'(sdd_q[QW-1].d1x * signed'({1'b0, q2_q[QW-1]}));
    oy2_q <= XW'(sdd_q[QW-1].d1y * signed'({1'b0, q2_q[QW-1]}));
  end

  // point stage 2: round, add start point, zero unused fields
  localparam logic signed [XW-1:0] Half = XW'(1) <<< (FB - 1);
  logic signed [XW-1:0] tx1, ty1, tx2, ty2;
  logic signed [CW-1:0] fx_d, fy_d, sx_d, sy_d;
  logic [QW-1:0]        ff_d, sf_d;

  always_comb begin
    tx1  = (ox1_q + Half) >>> FB;
    ty1  = (oy1_q + Half) >>> FB;
    tx2  = (ox2_q + Half) >>> FB;
    ty2  = (oy2_q + Half) >>> FB;
    fx_d = '0;
    fy_d = '0;
    ff_d = '0;
    sx_d = '0;
    sy_d = '0;
    sf_d = '0;
    if (sdp_q.kind != KIND_NONE) begin
      fx_d = sdp_q.s1x + tx1[CW-1:0];
      fy_d = sdp_q.s1y + ty1[CW-1:0];
      ff_d = qf1_q;
    end
    if (sdp_q.kind == KIND_OVERLAP) begin
      sx_d = sdp_q.s1x + tx2[CW-1:0];
      sy_d = sdp_q.s1y + ty2[CW-1:0];
      sf_d = qf2_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_kind_o        <= sdp_q.kind;
    first_x_o         <= fx_d;
    first_y_o         <= fy_d;
    first_fraction_o  <= ff_d;
    second_x_o        <= sx_d;
    second_y_o        <= sy_d;
    second_fraction_o <= sf_d;
  end

  // checks
  `SIT_ASSERT_IMPL(a_none_zero, clk_i, rst_ni, done_o && (hit_kind_o == KIND_NONE), (first_x_o == '0) && (first_y_o == '0) && (first_fraction_o == '0))
  `SIT_ASSERT_IMPL(a_point_no_second, clk_i, rst_ni, done_o && (hit_kind_o != KIND_OVERLAP), (second_x_o == '0) && (second_y_o == '0) && (second_fraction_o == '0))
  `SIT_ASSERT_NEVER(a_frac_range, clk_i, rst_ni, done_o && (first_fraction_o > (QW'(1) << FB)))

endmodule
